### hw/rtl/sps_pkg.sv
// sps_pkg: shared types and codes for the segmented prime sieve
// token struct handed along the cell chain, op and status codes
// no dependencies
package sps_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_TEST  = 2'd2,
    OP_NONE  = 2'd3
  } sps_op_e;

  typedef enum logic [1:0] {
    K_CLEAR = 2'd0,
    K_LOAD  = 2'd1,
    K_TEST  = 2'd2,
    K_PASS  = 2'd3
  } sps_kind_e;

  typedef enum logic [1:0] {
    FS_IDLE = 2'd0,
    FS_DIV  = 2'd1,
    FS_INJ  = 2'd2
  } sps_fstate_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SEQ  = 2'd2;
  localparam logic [1:0] ST_BADP = 2'd3;

  localparam logic CFG_WMIN = 1'b0;
  localparam logic CFG_WMAX = 1'b1;

  localparam int unsigned NumW  = 31;
  localparam int unsigned MultW = 32;

  typedef struct packed {
    logic             valid;
    sps_kind_e        kind;
    logic [NumW-1:0]  number;    // candidate, or prime for a load
    logic [MultW-1:0] mult;      // first multiple for a load
    logic [1:0]       status;
    logic             composite;
    logic             taken;     // load already captured by a cell
  } sps_tok_t;

endpackage

### hw/rtl/sps_front.sv
// sps_front: window registers, sequence check, cell count and the
// serial divider that finds a new prime's first multiple; feeds the chain
// depends on sps_pkg
module sps_front import sps_pkg::*; #(
  parameter int unsigned NUM_CELLS = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      in_op_i,
  input  logic [NumW-1:0] in_value_i,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [NumW-1:0] cfg_wdata_i,
  input  logic            adv_i,
  output sps_tok_t        tok_o
);

  localparam int unsigned UsedW = $clog2(NUM_CELLS + 1);

  sps_fstate_e      state_q, state_d;
  sps_tok_t         tok_q, tok_d;
  logic [NumW-1:0]  wmin_q, wmax_q;
  logic [MultW-1:0] exp_q;
  logic [UsedW-1:0] used_q;
  logic [MultW-1:0] dvd_q, dvd_d;
  logic [NumW-1:0]  div_q;
  logic [NumW-1:0]  rem_q, rem_d;
  logic [4:0]       cnt_q;

  sps_op_e          op;
  logic             in_fire;
  logic             load_ok;
  logic             test_ok;
  logic [MultW-1:0] rem_sh;
  logic [NumW-1:0]  gap;
  logic [MultW-1:0] mult;

  assign op      = sps_op_e'(in_op_i);
  assign in_fire = in_valid_i && in_ready_o;
  assign load_ok = (op == OP_LOAD) && (in_value_i >= NumW'(2))
                   && (used_q != UsedW'(NUM_CELLS));
  assign test_ok = ({1'b0, in_value_i} == exp_q) && (in_value_i >= wmin_q)
                   && (in_value_i <= wmax_q);

  // one restoring division step per cycle, quotient bits dropped
  always_comb begin
    rem_sh = {rem_q, dvd_q[MultW-1]};
    dvd_d  = {dvd_q[MultW-2:0], 1'b0};
    if (rem_sh >= {1'b0, div_q}) begin
      rem_d = NumW'(rem_sh - {1'b0, div_q});
    end else begin
      rem_d = NumW'(rem_sh);
    end
  end

  // base minus remainder plus prime, base when it divides evenly
  assign gap  = div_q - rem_q;
  assign mult = (rem_q == '0) ? exp_q : exp_q + {1'b0, gap};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FS_IDLE: if (in_fire && load_ok) state_d = FS_DIV;
      FS_DIV:  if (cnt_q == '1) state_d = FS_INJ;
      FS_INJ:  if (adv_i) state_d = FS_IDLE;
      default: state_d = FS_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == FS_IDLE) && adv_i;
    tok_d      = '0;
    if (state_q == FS_INJ) begin
      tok_d.valid  = 1'b1;
      tok_d.kind   = K_LOAD;
      tok_d.number = div_q;
      tok_d.mult   = mult;
      tok_d.status = ST_OK;
    end else if (in_fire && !load_ok) begin
      tok_d.valid  = 1'b1;
      tok_d.number = in_value_i;
      tok_d.status = ST_OK;
      tok_d.kind   = K_PASS;
      unique case (op)
        OP_CLEAR: tok_d.kind = K_CLEAR;
        OP_LOAD: begin
          tok_d.status = (in_value_i < NumW'(2)) ? ST_BADP : ST_FULL;
        end
        OP_TEST: begin
          if (test_ok) begin
            tok_d.kind = K_TEST;
          end else begin
            tok_d.status = ST_SEQ;
          end
        end
        OP_NONE: tok_d.kind = K_PASS;
        default: tok_d.kind = K_PASS;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      tok_q   <= '0;
    end else begin
      state_q <= state_d;
      if (adv_i) tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wmin_q <= NumW'(2);
      wmax_q <= '1;
      exp_q  <= MultW'(2);
      used_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (in_fire) begin
        unique case (op)
          OP_CLEAR: begin
            used_q <= '0;
            exp_q  <= {1'b0, wmin_q};
          end
          OP_LOAD: begin
            if (load_ok) begin
              used_q <= used_q + 1'b1;
              cnt_q  <= '0;
            end
          end
          OP_TEST: if (test_ok) exp_q <= {1'b0, in_value_i} + 1'b1;
          OP_NONE: ;
          default: ;
        endcase
      end
      if (state_q == FS_DIV) cnt_q <= cnt_q + 1'b1;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_WMIN: begin
            wmin_q <= cfg_wdata_i;
            exp_q  <= {1'b0, cfg_wdata_i};
          end
          CFG_WMAX: wmax_q <= cfg_wdata_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && load_ok) begin
      dvd_q <= exp_q;
      div_q <= in_value_i;
      rem_q <= '0;
    end else if (state_q == FS_DIV) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign tok_o = tok_q;

endmodule

### hw/rtl/sps_cell.sv
// sps_cell: one sieve cell holding a base prime and its next multiple
// takes the token from its left neighbour and registers it for the right
// depends on sps_pkg
module sps_cell import sps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  sps_tok_t tok_i,
  output sps_tok_t tok_o
);

  logic             used_q;
  logic [NumW-1:0]  prime_q;
  logic [MultW-1:0] next_q;
  sps_tok_t         tok_q, tok_d;
  logic             hit;
  logic             grab;

  assign hit  = used_q && (next_q == {1'b0, tok_i.number});
  assign grab = !used_q && !tok_i.taken;

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid) begin
      case (tok_i.kind)
        K_LOAD:  if (grab) tok_d.taken = 1'b1;
        K_TEST:  if (hit && (prime_q != tok_i.number)) tok_d.composite = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      tok_q  <= '0;
    end else if (adv_i) begin
      tok_q <= tok_d;
      if (tok_i.valid && (tok_i.kind == K_CLEAR)) used_q <= 1'b0;
      if (tok_i.valid && (tok_i.kind == K_LOAD) && grab) used_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && tok_i.valid) begin
      if ((tok_i.kind == K_LOAD) && grab) begin
        prime_q <= tok_i.number;
        next_q  <= tok_i.mult;
      end else if ((tok_i.kind == K_TEST) && hit) begin
        next_q <= next_q + {1'b0, prime_q};
      end
    end
  end

  assign tok_o = tok_q;

endmodule

### hw/rtl/segmented_prime_sieve.sv
// segmented_prime_sieve: streaming segmented sieve, front end, cell chain
// and output register
// depends on sps_pkg, sps_front, sps_cell
//
//   port group   direction  contents
//   in_*         in         op, value; valid/ready
//   out_*        out        number, is_prime, status; valid/ready
//   cfg_*        in         window_min (index 0), window_max (index 1)
//
// clears and candidate tests enter one per cycle unless the output stalls
// or a load is busy, and pass in order through the front, cell and
// output registers; a base prime load holds the input while the divider
// takes one remainder bit per cycle over the 32-bit window position
// a stalled output freezes the whole chain; no clearing pass after reset
module segmented_prime_sieve import sps_pkg::*; #(
  parameter int unsigned NUM_CELLS = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      in_op_i,
  input  logic [NumW-1:0] in_value_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [NumW-1:0] out_number_o,
  output logic            out_is_prime_o,
  output logic [1:0]      out_status_o,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [NumW-1:0] cfg_wdata_i
);

  sps_tok_t        chain [NUM_CELLS+1];
  logic            adv;
  logic            out_valid_q;
  logic [NumW-1:0] number_q;
  logic            is_prime_q;
  logic [1:0]      status_q;
  sps_tok_t        last;

  assign adv  = !out_valid_q || out_ready_i;
  assign last = chain[NUM_CELLS];

  sps_front #(
    .NUM_CELLS (NUM_CELLS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_op_i     (in_op_i),
    .in_value_i  (in_value_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .adv_i       (adv),
    .tok_o       (chain[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    sps_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tok_i  (chain[i]),
      .tok_o  (chain[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last.valid) begin
      number_q   <= last.number;
      status_q   <= last.status;
      is_prime_q <= (last.kind == K_TEST) && !last.composite
                    && (last.number >= NumW'(2));
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_number_o   = number_q;
  assign out_is_prime_o = is_prime_q;
  assign out_status_o   = status_q;

endmodule
